@@ sv/prm_pkg.sv @@
`default_nettype none

package prm_pkg;

  localparam int unsigned SampleFieldBits = 24;
  localparam int unsigned LevelBits       = 24;
  localparam int unsigned CountBits       = 17;
  localparam int unsigned SumBits         = 63;

  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned SampleBits = 24;

  localparam int unsigned MagBits  = SampleBits;
  localparam int unsigned SqBits   = 2 * MagBits;
  localparam int unsigned RadBits  = SumBits + (SumBits % 2);
  localparam int unsigned RootBits = RadBits / 2;
  localparam int unsigned RemBits  = RootBits + 2;

  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

`default_nettype wire

@@ sv/prm_stream_if.sv @@
`default_nettype none

interface prm_sample_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [prm_pkg::SampleFieldBits-1:0] sample;
  logic                                        last_of_block;

  modport source (output valid, output sample, output last_of_block, input ready);
  modport sink   (input valid, input sample, input last_of_block, output ready);
endinterface

interface prm_result_if;
  logic                              valid;
  logic                              ready;
  logic [prm_pkg::LevelBits-1:0]     peak_level;
  logic [prm_pkg::LevelBits-1:0]     rms_level;
  logic [prm_pkg::CountBits-1:0]     samples_counted;
  logic                              too_long;

  modport source (output valid, output peak_level, output rms_level,
                  output samples_counted, output too_long, input ready);
  modport sink   (input valid, input peak_level, input rms_level,
                  input samples_counted, input too_long, output ready);
endinterface

`default_nettype wire

@@ sv/prm_square.sv @@
`default_nettype none

module prm_square (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prm_pkg::unit_ctl_t          ctl_i,
  input  logic [prm_pkg::MagBits-1:0] mag_i,
  output prm_pkg::unit_sts_t          sts_o,
  output logic [prm_pkg::SqBits-1:0]  square_o
);

  localparam int unsigned W    = prm_pkg::MagBits;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]      mcand_q, mcand_d;
  logic [W-1:0]      mplier_q, mplier_d;
  logic [2*W-1:0]    acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [W:0]        partial;

  // shift-and-add, one multiplier bit per cycle
  assign partial = {1'b0, acc_q[2*W-1:W]} + (mplier_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (ctl_i.start && !busy_q) begin
      mcand_d  = mag_i;
      mplier_d = mag_i;
      acc_d    = '0;
      cnt_d    = CntW'(W);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      acc_d    = {partial, acc_q[W-1:1]};
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign square_o   = acc_q;

endmodule

`default_nettype wire

@@ sv/prm_divider.sv @@
`default_nettype none

module prm_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prm_pkg::unit_ctl_t            ctl_i,
  input  logic [prm_pkg::SumBits-1:0]   dividend_i,
  input  logic [prm_pkg::CountBits-1:0] divisor_i,
  output prm_pkg::unit_sts_t            sts_o,
  output logic [prm_pkg::SumBits-1:0]   quotient_o
);

  localparam int unsigned NW   = prm_pkg::SumBits;
  localparam int unsigned DW   = prm_pkg::CountBits;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   div_q, div_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     shifted;
  logic [DW:0]     diff;
  logic            ge;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[NW-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start && !busy_q) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CntW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ sv/prm_isqrt.sv @@
`default_nettype none

module prm_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  prm_pkg::unit_ctl_t           ctl_i,
  input  logic [prm_pkg::SumBits-1:0]  radicand_i,
  output prm_pkg::unit_sts_t           sts_o,
  output logic [prm_pkg::RootBits-1:0] root_o
);

  localparam int unsigned RW   = prm_pkg::RadBits;
  localparam int unsigned QW   = prm_pkg::RootBits;
  localparam int unsigned MW   = prm_pkg::RemBits;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [RW-1:0]   rad_q, rad_d;
  logic [QW-1:0]   root_q, root_d;
  logic [MW-1:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [MW+1:0]   rem_sh;
  logic [MW+1:0]   trial;
  logic [MW+1:0]   diff;
  logic            ge;

  // digit-by-digit root, two radicand bits per cycle
  assign rem_sh = {rem_q, rad_q[RW-1 -: 2]};
  assign trial  = (MW + 2)'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_comb begin
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start && !busy_q) begin
      rad_d  = RW'(radicand_i);
      root_d = '0;
      rem_d  = '0;
      cnt_d  = CntW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[MW-1:0] : rem_sh[MW-1:0];
      root_d = {root_q[QW-2:0], ge};
      rad_d  = rad_q << 2;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

`default_nettype wire

@@ sv/block_peak_rms_meter_top.sv @@
// Peak and RMS meter over one audio block. Feed every sample of the block, all
// channels interleaved, one transaction each; the transaction marked last_of_block
// yields one result (peak magnitude, floor(sqrt(sum of squares / count)), count,
// too-long flag) and clears the state for the next block. An ordinary sample goes
// through the bit-serial squarer (one bit of the magnitude a cycle); no new sample
// is taken until it is done. The last sample of a block then goes on to the
// restoring divider and the digit-by-digit root. Past 65536 samples the sum and
// count hold, the peak still follows, and too_long is set; such samples skip the
// squarer and the last goes straight to the divider. A finished result waits in an
// output register while new samples are taken; only a second report stalls on it.
`default_nettype none

module block_peak_rms_meter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  prm_sample_if.sink          sample_i,
  prm_result_if.source        result_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSqr   = 3'd1;
  localparam logic [2:0] StDivGo = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StSqrt  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  localparam int unsigned MagW = prm_pkg::MagBits;

  logic [2:0]                    state_q, state_d;
  logic [MagW-1:0]               peak_q, peak_d;
  logic [prm_pkg::SumBits-1:0]   sum_q, sum_d;
  logic [prm_pkg::CountBits-1:0] count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic                          last_q, last_d;

  logic                          out_valid_q, out_valid_d;
  logic [prm_pkg::LevelBits-1:0] out_peak_q, out_rms_q;
  logic [prm_pkg::CountBits-1:0] out_count_q;
  logic                          out_long_q;
  logic                          out_load;

  logic                          accept;
  logic [MagW-1:0]               raw;
  logic [MagW-1:0]               mag;
  logic                          room;

  prm_pkg::unit_ctl_t            sqr_ctl, div_ctl, sqrt_ctl;
  prm_pkg::unit_sts_t            sqr_sts, div_sts, sqrt_sts;
  logic [prm_pkg::SqBits-1:0]    square;
  logic [prm_pkg::SumBits-1:0]   quotient;
  logic [prm_pkg::RootBits-1:0]  root;

  assign raw  = sample_i.sample[MagW-1:0];
  assign mag  = raw[MagW-1] ? (~raw + 1'b1) : raw;
  assign room = count_q < prm_pkg::CountBits'(prm_pkg::MaxSamples);

  assign sample_i.ready = (state_q == StIdle);
  assign accept         = sample_i.valid && sample_i.ready;
  assign out_load       = (state_q == StOut) && (!out_valid_q || result_o.ready);

  assign sqr_ctl.start  = accept && room;
  assign div_ctl.start  = (state_q == StDivGo);
  assign sqrt_ctl.start = (state_q == StDiv) && div_sts.done;

  prm_square u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (sqr_ctl),
    .mag_i    (mag),
    .sts_o    (sqr_sts),
    .square_o (square)
  );

  prm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  prm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sqrt_ctl),
    .radicand_i (quotient),
    .sts_o      (sqrt_sts),
    .root_o     (root)
  );

  always_comb begin
    state_d = state_q;
    peak_d  = peak_q;
    sum_d   = sum_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    last_d  = last_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          last_d = sample_i.last_of_block;
          if (mag > peak_q) begin
            peak_d = mag;
          end
          if (room) begin
            state_d = StSqr;
          end else begin
            ovf_d   = 1'b1;
            state_d = sample_i.last_of_block ? StDivGo : StIdle;
          end
        end
      end
      StSqr: begin
        if (sqr_sts.done) begin
          sum_d   = sum_q + prm_pkg::SumBits'(square);
          count_d = count_q + 1'b1;
          state_d = last_q ? StDivGo : StIdle;
        end
      end
      StDivGo: state_d = StDiv;
      StDiv: begin
        if (div_sts.done) begin
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        if (sqrt_sts.done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_load) begin
          peak_d  = '0;
          sum_d   = '0;
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      peak_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_peak_q  <= prm_pkg::LevelBits'(peak_q);
      out_rms_q   <= root[prm_pkg::LevelBits-1:0];
      out_count_q <= count_q;
      out_long_q  <= ovf_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.peak_level      = out_peak_q;
  assign result_o.rms_level       = out_rms_q;
  assign result_o.samples_counted = out_count_q;
  assign result_o.too_long        = out_long_q;

  a_clear_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (count_q == '0) && (sum_q == '0) && (peak_q == '0) && !ovf_q)
    else $error("block state not cleared after report");

  a_sqr_done_in_sqr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqr_sts.done |-> (state_q == StSqr))
    else $error("squarer finished outside its state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == StDiv) && !sqrt_sts.busy)
    else $error("divider finished out of sequence");

  a_report_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> (result_o.samples_counted != '0))
    else $error("report with zero sample count");

endmodule

`default_nettype wire
